[rtl/core/ipba_pkg.sv]
`timescale 1ns / 1ps

package ipba_pkg;

  // command codes
  localparam logic [1:0] CMD_USE   = 2'd0;
  localparam logic [1:0] CMD_FREE  = 2'd1;
  localparam logic [1:0] CMD_QUERY = 2'd2;

  // status codes
  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_NOT_MEMBER = 2'd1;
  localparam logic [1:0] ST_DOUBLE     = 2'd2;
  localparam logic [1:0] ST_BEYOND     = 2'd3;

  // configuration register indexes
  localparam logic [1:0] REG_BASE_FIRST  = 2'd0;
  localparam logic [1:0] REG_BASE_MIDDLE = 2'd1;
  localparam logic [1:0] REG_BASE_TAIL   = 2'd2;
  localparam logic [1:0] REG_POOL_LIMIT  = 2'd3;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 64;
  localparam int ROW_W      = 32;
  localparam int ROW_BIT_W  = 5;
  localparam int FREE_OFF_W = 9;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [31:0] id_first_word;
    logic [31:0] id_middle_words;
    logic [63:0] id_tail_bytes;
  } in_word_t;

  typedef struct packed {
    logic                  is_member;
    logic [1:0]            status;
    logic [FREE_OFF_W-1:0] free_offset;
    logic [31:0]           free_id_first_word;
    logic                  pool_full;
  } out_word_t;

  typedef struct packed {
    logic [31:0] base_first_word;
    logic [31:0] base_middle_words;
    logic [63:0] base_tail_bytes;
    logic [31:0] pool_limit;
  } cfg_t;

  // controller to datapath commands
  typedef struct packed {
    logic load;
    logic lookup;
    logic update;
    logic find;
    logic finish;
  } dp_cmd_t;

endpackage

[rtl/core/ipba_ctrl.sv]
`timescale 1ns / 1ps

module ipba_ctrl
  import ipba_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    start,
  output logic    busy,
  output logic    out_valid,
  output dp_cmd_t dp_cmd
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_CHECK  = 5'b00010,
    S_UPDATE = 5'b00100,
    S_FIND   = 5'b01000,
    S_SCAN   = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:   if (start) state_nxt = S_CHECK;
      S_CHECK:  state_nxt = S_UPDATE;
      S_UPDATE: state_nxt = S_FIND;
      S_FIND:   state_nxt = S_SCAN;
      S_SCAN:   state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= (state_r == S_SCAN);
    end
  end

  assign busy          = (state_r != S_IDLE);
  assign out_valid     = out_valid_r;
  assign dp_cmd.load   = (state_r == S_IDLE) && start;
  assign dp_cmd.lookup = (state_r == S_CHECK);
  assign dp_cmd.update = (state_r == S_UPDATE);
  assign dp_cmd.find   = (state_r == S_FIND);
  assign dp_cmd.finish = (state_r == S_SCAN);

endmodule

[rtl/core/ipba_dp.sv]
`timescale 1ns / 1ps

module ipba_dp
  import ipba_pkg::*;
#(
  parameter int CAPACITY = 256
) (
  input  logic      clk,
  input  logic      rst_n,
  input  dp_cmd_t   dp_cmd,
  input  cfg_t      cfg,
  input  in_word_t  in_data,
  output out_word_t out_data
);

  localparam int ROWS   = (CAPACITY + ROW_W - 1) / ROW_W;
  localparam int ROW_AW = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int OFF_W  = $clog2(CAPACITY + 1);

  // item registers
  in_word_t              in_r;
  logic                  member_r;
  logic                  beyond_r;
  logic [ROW_AW-1:0]     row_r;
  logic [ROW_BIT_W-1:0]  bit_r;
  logic [1:0]            status_r;
  logic [ROW_AW-1:0]     find_row_r;
  logic                  any_free_r;
  out_word_t             out_r;

  // bitmap storage: rows in memory, per-row valid and full flags in flops
  logic [ROW_W-1:0]      mem [ROWS];
  logic [ROW_W-1:0]      rd_data_r;
  logic                  rd_vld_r;
  logic [ROWS-1:0]       row_vld_r;
  logic [ROWS-1:0]       row_full_r;

  logic [31:0]           off;
  logic                  member;
  logic [ROW_AW-1:0]     rd_addr;
  logic [ROW_W-1:0]      row_cur;
  logic [ROW_W-1:0]      row_new;
  logic                  row_we;
  logic [1:0]            status_nxt;
  logic [ROW_W-1:0]      last_pad;
  logic [ROW_W-1:0]      row_pad;
  logic [ROW_W-1:0]      scan_row;
  logic                  free_found;
  logic [ROW_AW-1:0]     free_row;
  logic [ROW_BIT_W-1:0]  free_bit;
  logic [OFF_W-1:0]      free_off;
  logic [31:0]           free_off_ext;

  // membership check
  assign off    = in_r.id_first_word - cfg.base_first_word;
  assign member = (in_r.id_middle_words == cfg.base_middle_words)
                  && (in_r.id_tail_bytes == cfg.base_tail_bytes)
                  && (off <= cfg.pool_limit);

  // offsets past capacity in the last row count as used
  always_comb begin
    for (int b = 0; b < ROW_W; b++) begin
      last_pad[b] = (((ROWS - 1) * ROW_W + b) >= CAPACITY);
    end
  end

  assign row_cur = rd_vld_r ? rd_data_r : '0;

  // bit update and status
  always_comb begin
    status_nxt = ST_OK;
    row_new    = row_cur;
    row_we     = 1'b0;
    if (!member_r) begin
      status_nxt = ST_NOT_MEMBER;
    end else if (beyond_r) begin
      status_nxt = ST_BEYOND;
    end else begin
      case (in_r.cmd)
        CMD_USE: begin
          status_nxt     = row_cur[bit_r] ? ST_DOUBLE : ST_OK;
          row_new[bit_r] = 1'b1;
          row_we         = 1'b1;
        end
        CMD_FREE: begin
          status_nxt     = row_cur[bit_r] ? ST_OK : ST_DOUBLE;
          row_new[bit_r] = 1'b0;
          row_we         = 1'b1;
        end
        default: status_nxt = ST_OK;
      endcase
    end
  end

  assign row_pad = (row_r == ROW_AW'(ROWS - 1)) ? last_pad : '0;

  // lowest row that still has a free offset
  always_comb begin
    free_found = 1'b0;
    free_row   = '0;
    for (int i = ROWS - 1; i >= 0; i--) begin
      if (!row_full_r[i]) begin
        free_found = 1'b1;
        free_row   = ROW_AW'(i);
      end
    end
  end

  assign rd_addr = dp_cmd.find ? free_row : off[ROW_AW+ROW_BIT_W-1:ROW_BIT_W];

  // lowest free bit inside the selected row
  assign scan_row = row_cur | ((find_row_r == ROW_AW'(ROWS - 1)) ? last_pad : '0);

  always_comb begin
    free_bit = '0;
    for (int b = ROW_W - 1; b >= 0; b--) begin
      if (!scan_row[b]) free_bit = ROW_BIT_W'(b);
    end
  end

  assign free_off     = any_free_r ? OFF_W'({find_row_r, free_bit}) : OFF_W'(CAPACITY);
  assign free_off_ext = 32'(free_off);

  // memory
  always_ff @(posedge clk) begin
    if (dp_cmd.update && row_we) mem[row_r] <= row_new;
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_vld_r  <= '0;
      row_full_r <= '0;
      rd_vld_r   <= 1'b0;
    end else begin
      rd_vld_r <= row_vld_r[rd_addr];
      if (dp_cmd.update && row_we) begin
        row_vld_r[row_r]  <= 1'b1;
        row_full_r[row_r] <= &(row_new | row_pad);
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (dp_cmd.load) in_r <= in_data;
    if (dp_cmd.lookup) begin
      member_r <= member;
      beyond_r <= (off >= 32'(CAPACITY));
      row_r    <= off[ROW_AW+ROW_BIT_W-1:ROW_BIT_W];
      bit_r    <= off[ROW_BIT_W-1:0];
    end
    if (dp_cmd.update) status_r <= status_nxt;
    if (dp_cmd.find) begin
      find_row_r <= free_row;
      any_free_r <= free_found;
    end
    if (dp_cmd.finish) begin
      out_r.is_member          <= member_r;
      out_r.status             <= status_r;
      out_r.free_offset        <= free_off_ext[FREE_OFF_W-1:0];
      out_r.free_id_first_word <= cfg.base_first_word + free_off_ext;
      out_r.pool_full          <= !any_free_r;
    end
  end

  assign out_data = out_r;

endmodule

[rtl/core/id_pool_bitmap_allocator.sv]
`timescale 1ns / 1ps

// identifier pool allocator with a usage bitmap and lowest-free search
// input channel: an item (command plus 128-bit identifier on in_data) is
//   taken at a clock edge where start is high and busy is low
// result channel: one word per item on out_data, valid for exactly one cycle
//   while out_valid is high; the receiver cannot stall, so nothing waits
// config port: cfg_we, cfg_index, cfg_wdata write one register per edge;
//   the user writes only while the block is idle; not enforced by the block
// sequence: the item passes check, update, row search and in-row scan,
//   one state each; out_valid rises after the scan state, and a new item
//   may be taken while out_valid is high, not before the last is through
// the sequence is set by the bitmap memory port: one read for the touched
//   row, then one read for the lowest non-full row
// reset: bitmap reads as all free (per-row valid flags), base registers
//   clear to zero, pool limit goes to all ones, no clearing pass needed
module id_pool_bitmap_allocator
  import ipba_pkg::*;
#(
  parameter int CAPACITY = 256
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // input channel
  input  logic                  start,
  output logic                  busy,
  input  in_word_t              in_data,
  // result channel
  output logic                  out_valid,
  output out_word_t             out_data,
  // config port
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_t    cfg_r;
  dp_cmd_t dp_cmd;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.base_first_word   <= '0;
      cfg_r.base_middle_words <= '0;
      cfg_r.base_tail_bytes   <= '0;
      cfg_r.pool_limit        <= '1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BASE_FIRST:  cfg_r.base_first_word   <= cfg_wdata[31:0];
        REG_BASE_MIDDLE: cfg_r.base_middle_words <= cfg_wdata[31:0];
        REG_BASE_TAIL:   cfg_r.base_tail_bytes   <= cfg_wdata;
        REG_POOL_LIMIT:  cfg_r.pool_limit        <= cfg_wdata[31:0];
        default: ;
      endcase
    end
  end

  // sequencer
  ipba_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .dp_cmd    (dp_cmd)
  );

  // membership, bitmap and search
  ipba_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .dp_cmd   (dp_cmd),
    .cfg      (cfg_r),
    .in_data  (in_data),
    .out_data (out_data)
  );

endmodule
